// ===== hw/rtl/palette_dac_with_fade_unit_macros.svh =====
// ----------------------------------------------------------------------------
// palette_dac_with_fade_unit_macros
// Assertion macros for the palette DAC.
// ----------------------------------------------------------------------------
`ifndef PALETTE_DAC_WITH_FADE_UNIT_MACROS_SVH
`define PALETTE_DAC_WITH_FADE_UNIT_MACROS_SVH
// assert that a implies b at the next edge
`define PDF_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// assert that a implies b at the same edge
`define PDF_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the palette DAC with fade.
// ----------------------------------------------------------------------------
package pdf_pkg;
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_PIXEL = 2'd2,
        REQ_FADE  = 2'd3
    } t_req;

    localparam logic [2:0] CFG_TRED  = 3'd0;
    localparam logic [2:0] CFG_TGRN  = 3'd1;
    localparam logic [2:0] CFG_TBLU  = 3'd2;
    localparam logic [2:0] CFG_STEPS = 3'd3;
    localparam logic [2:0] CFG_FIRST = 3'd4;
    localparam logic [2:0] CFG_LAST  = 3'd5;
    localparam logic [2:0] CFG_HUD   = 3'd6;
    localparam logic [2:0] CFG_FEN   = 3'd7;

    // queued word between front and back
    typedef struct packed {
        t_req       req;
        logic [7:0] index;
        logic [17:0] rgb;
        logic       mask;
        logic       fill;
        logic [7:0] step;
    } t_cmd;

    // 6-bit level to 8-bit: (255*c)/63 == 4c + c/21
    function automatic logic [7:0] expand_level(input logic [5:0] c);
        logic [1:0] f;
        if (c == 6'd63)       f = 2'd3;
        else if (c >= 6'd42)  f = 2'd2;
        else if (c >= 6'd21)  f = 2'd1;
        else                  f = 2'd0;
        return {c, 2'b00} + {6'd0, f};
    endfunction
endpackage

// ===== hw/rtl/pdf_front.sv =====
// ----------------------------------------------------------------------------
// pdf_front
// Accepts requests, classifies fade steps and queues commands.
// ----------------------------------------------------------------------------
module pdf_front #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pdf_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_steps,
    input  logic            i_fade_en,
    output logic            o_valid,
    input  logic            i_take,
    output pdf_pkg::t_cmd   o_cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    pdf_pkg::t_cmd r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    pdf_pkg::t_cmd c;
    logic          push, pop;

    // classify: a fade step at or past the count, or with fading off, fills
    always_comb begin
        c = i_cmd;
        c.fill = !i_fade_en || (i_cmd.step >= i_steps);
    end

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_take;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= c;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== hw/rtl/pdf_div.sv =====
// ----------------------------------------------------------------------------
// pdf_div
// Signed blend: base + (delta*i)/steps, restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module pdf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [5:0]  i_base,
    input  logic [5:0]  i_target,
    input  logic [7:0]  i_step,
    input  logic [7:0]  i_steps,
    output logic        o_done,
    output logic [5:0]  o_level
);
    logic [13:0] r_num, n_num;
    logic [13:0] r_quo, n_quo;
    logic [7:0]  r_rem;
    logic [8:0]  n_rem;
    logic [3:0]  r_cnt;
    logic        r_neg, r_busy;
    logic [5:0]  r_base;
    logic [6:0]  dlt;
    logic [6:0]  mag;
    logic [13:0] prod;
    logic [13:0] q;

    assign dlt  = {1'b0, i_target} - {1'b0, i_base};
    assign mag  = dlt[6] ? 7'(-dlt) : dlt;
    assign prod = mag * i_step;

    // one quotient bit per cycle
    always_comb begin
        n_rem = {r_rem, r_num[13]};
        n_num = {r_num[12:0], 1'b0};
        n_quo = {r_quo[12:0], 1'b0};
        if (n_rem >= {1'b0, i_steps}) begin
            n_rem = n_rem - {1'b0, i_steps};
            n_quo[0] = 1'b1;
        end
    end

    assign q       = r_neg ? 14'(-r_quo) : r_quo;
    assign o_level = r_base + q[5:0];
    assign o_done  = r_busy && (r_cnt == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_cnt <= 4'd14;
            r_num <= prod; r_quo <= '0; r_rem <= '0;
            r_neg <= dlt[6]; r_base <= i_base;
        end else if (r_busy) begin
            if (r_cnt == 4'd0) r_busy <= 1'b0;
            else begin
                r_cnt <= r_cnt - 1'b1;
                r_num <= n_num; r_quo <= n_quo; r_rem <= n_rem[7:0];
            end
        end
    end
endmodule

// ===== hw/rtl/pdf_back.sv =====
// ----------------------------------------------------------------------------
// pdf_back
// Executes commands against the palettes, sweeps fades and fills, and a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module pdf_back #(
    parameter int ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_take,
    input  pdf_pkg::t_cmd i_cmd,
    input  logic [17:0]   i_target,
    input  logic [7:0]    i_steps,
    input  logic [7:0]    i_first,
    input  logic [7:0]    i_last,
    input  logic          i_hud,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [31:0]   o_argb,
    output logic [5:0]    o_red,
    output logic [5:0]    o_green,
    output logic [5:0]    o_blue,
    output logic          o_busy
);
    localparam int AW = $clog2(ENTRIES);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_LOOK = 7'b0000100,
        S_FILL  = 7'b0001000, S_FRD  = 7'b0010000, S_FDIV = 7'b0100000,
        S_FWR   = 7'b1000000
    } t_state;
    t_state r_st;

    logic [17:0] r_base [ENTRIES];
    logic [17:0] r_shown [ENTRIES];
    logic [17:0] r_brd, r_srd;
    logic        r_we;
    logic [AW-1:0] r_wa, r_ra, r_ptr;
    logic [AW-1:0] ra;
    logic [17:0] r_wb, r_ws;
    logic        r_wbase;
    pdf_pkg::t_cmd r_cmd;
    logic        r_ov;
    logic [31:0] r_argb;
    logic [5:0]  r_r, r_g, r_b;
    logic [1:0]  r_ch;
    logic [17:0] r_acc;
    logic        ddone;
    logic        r_kick;
    logic        inr_q;
    logic [5:0]  dbase, dtgt, dlev;
    logic        inr, outb, last_ptr, in_fade;
    logic [7:0]  ptr8;

    assign inr = (ENTRIES >= 256) || ({1'b0, i_cmd.index} < 9'(ENTRIES));
    assign outb = !o_valid || !i_stall;
    assign o_take = (r_st == S_IDLE) && !r_we &&
        ((i_cmd.req == pdf_pkg::REQ_WRITE) || (i_cmd.req == pdf_pkg::REQ_FADE)
         || outb);
    assign o_valid = r_ov;
    assign o_argb = r_argb; assign o_red = r_r; assign o_green = r_g; assign o_blue = r_b;
    assign o_busy = (r_st != S_IDLE) || r_we;
    assign last_ptr = (r_ptr == AW'(ENTRIES-1));
    assign ptr8 = 8'(r_ptr);
    assign in_fade = (ptr8 >= i_first) && (ptr8 <= i_last);

    // read address: the queue head while idle, so a lookup has its data next cycle
    assign ra = (r_st == S_IDLE) ? i_cmd.index[AW-1:0] : r_ra;

    // memories: one write, one read each
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_shown[r_wa] <= r_ws;
            if (r_wbase) r_base[r_wa] <= r_wb;
        end
        r_brd <= r_base[ra];
        r_srd <= r_shown[ra];
    end

    // channel select for the shared divider
    always_comb begin
        case (r_ch)
            2'd0: begin dbase = r_brd[17:12]; dtgt = i_target[17:12]; end
            2'd1: begin dbase = r_brd[11:6];  dtgt = i_target[11:6];  end
            default: begin dbase = r_brd[5:0]; dtgt = i_target[5:0]; end
        endcase
    end

    pdf_div u_div (
        .i_clk, .i_rst_n, .i_start(r_kick), .i_base(dbase), .i_target(dtgt),
        .i_step(r_cmd.step), .i_steps(i_steps), .o_done(ddone), .o_level(dlev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_ptr <= '0; r_we <= 1'b0; r_ov <= 1'b0;
            r_kick <= 1'b0; r_ch <= '0; r_acc <= '0;
        end else begin
            r_we <= 1'b0;
            r_kick <= 1'b0;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_CLEAR: begin
                    r_we <= 1'b1; r_wbase <= 1'b1; r_wa <= r_ptr;
                    r_wb <= '0; r_ws <= '0;
                    r_ptr <= r_ptr + 1'b1;
                    if (last_ptr) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_take) begin
                        r_cmd <= i_cmd;
                        r_ra <= i_cmd.index[AW-1:0];
                        unique case (i_cmd.req)
                            pdf_pkg::REQ_WRITE: begin
                                r_we <= inr; r_wbase <= 1'b1;
                                r_wa <= i_cmd.index[AW-1:0];
                                r_wb <= i_cmd.rgb; r_ws <= i_cmd.rgb;
                            end
                            pdf_pkg::REQ_READ, pdf_pkg::REQ_PIXEL: r_st <= S_LOOK;
                            pdf_pkg::REQ_FADE: begin
                                r_ptr <= '0;
                                r_st <= i_cmd.fill ? S_FILL : S_FRD;
                            end
                            default: r_st <= S_IDLE;
                        endcase
                    end
                end
                S_LOOK: begin
                    r_ov <= 1'b1;
                    if (r_cmd.req == pdf_pkg::REQ_READ) begin
                        r_argb <= '0;
                        r_r <= inr_q ? r_srd[17:12] : '0;
                        r_g <= inr_q ? r_srd[11:6] : '0;
                        r_b <= inr_q ? r_srd[5:0] : '0;
                    end else begin
                        r_r <= '0; r_g <= '0; r_b <= '0;
                        r_argb <= {(i_hud && !r_cmd.mask) ? 8'h00 : 8'hFF,
                            pdf_pkg::expand_level(inr_q ? r_srd[17:12] : 6'd0),
                            pdf_pkg::expand_level(inr_q ? r_srd[11:6] : 6'd0),
                            pdf_pkg::expand_level(inr_q ? r_srd[5:0] : 6'd0)};
                    end
                    r_st <= S_IDLE;
                end
                S_FILL: begin
                    r_we <= 1'b1; r_wbase <= 1'b1; r_wa <= r_ptr;
                    r_wb <= i_target; r_ws <= i_target;
                    r_ptr <= r_ptr + 1'b1;
                    if (last_ptr) r_st <= S_IDLE;
                end
                S_FRD: begin
                    r_ra <= r_ptr; r_ch <= '0; r_acc <= '0;
                    r_st <= S_FDIV;
                end
                S_FDIV: begin
                    // r_acc[0] marks a division in flight
                    if (!in_fade) begin
                        r_st <= S_FWR;
                    end else if (!r_acc[0]) begin
                        r_kick <= 1'b1; r_acc[0] <= 1'b1;
                    end else if (ddone) begin
                        r_acc[0] <= 1'b0;
                        case (r_ch)
                            2'd0: r_acc[17:12] <= dlev;
                            2'd1: r_acc[11:6] <= dlev;
                            default: r_acc[5:1] <= dlev[5:1];
                        endcase
                        if (r_ch == 2'd2) begin
                            r_wb <= {r_acc[17:6], dlev};
                            r_st <= S_FWR;
                        end
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_FWR: begin
                    r_we <= 1'b1; r_wbase <= 1'b0; r_wa <= r_ptr;
                    r_ws <= in_fade ? r_wb : r_brd;
                    r_ptr <= r_ptr + 1'b1;
                    r_st <= last_ptr ? S_IDLE : S_FRD;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) inr_q <= inr;
endmodule

// ===== hw/rtl/palette_dac_with_fade_unit.sv =====
// Palette DAC with fade. Requests pass a two-word queue before the palette
// engine. A write holds the engine while it is taken and until the palette
// write lands; a read or pixel lookup holds it through the take and the
// lookup state, and with the engine idle its word passes the queue, the take
// and the lookup state before it is offered. A fill sweeps the palette at one
// entry a cycle. A fade step runs the shared one-bit-a-cycle divider three
// times for every entry inside the fade range, and takes an entry outside it
// through the read, divide and write states without a division. After reset
// a clearing pass over every palette entry runs before the first item is taken.
// ----------------------------------------------------------------------------
// palette_dac_with_fade_unit
// Top level: config registers, request queue and palette engine.
// ----------------------------------------------------------------------------
`include "palette_dac_with_fade_unit_macros.svh"
module palette_dac_with_fade_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_index,
    input  logic [5:0]  i_red_in,
    input  logic [5:0]  i_green_in,
    input  logic [5:0]  i_blue_in,
    input  logic        i_mask_bit,
    input  logic [7:0]  i_step_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_argb,
    output logic [5:0]  o_red_out,
    output logic [5:0]  o_green_out,
    output logic [5:0]  o_blue_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    logic [5:0] r_tr, r_tg, r_tb;
    logic [7:0] r_steps, r_first, r_last;
    logic       r_hud, r_fen;
    pdf_pkg::t_cmd cin, qcmd;
    logic       qv, qtake, busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr <= '0; r_tg <= '0; r_tb <= '0; r_steps <= 8'd30;
            r_first <= '0; r_last <= 8'd255; r_hud <= 1'b0; r_fen <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdf_pkg::CFG_TRED:  r_tr <= i_cfg_data[5:0];
                pdf_pkg::CFG_TGRN:  r_tg <= i_cfg_data[5:0];
                pdf_pkg::CFG_TBLU:  r_tb <= i_cfg_data[5:0];
                pdf_pkg::CFG_STEPS: r_steps <= i_cfg_data;
                pdf_pkg::CFG_FIRST: r_first <= i_cfg_data;
                pdf_pkg::CFG_LAST:  r_last <= i_cfg_data;
                pdf_pkg::CFG_HUD:   r_hud <= i_cfg_data[0];
                pdf_pkg::CFG_FEN:   r_fen <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cin.req   = pdf_pkg::t_req'(i_req_type);
        cin.index = i_index;
        cin.rgb   = {i_red_in, i_green_in, i_blue_in};
        cin.mask  = i_mask_bit;
        cin.fill  = 1'b0;
        cin.step  = i_step_number;
    end

    pdf_front #(.DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd(cin), .i_steps(r_steps),
        .i_fade_en(r_fen), .o_valid(qv), .i_take(qtake), .o_cmd(qcmd)
    );

    pdf_back #(.ENTRIES(PALETTE_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_valid(qv), .o_take(qtake), .i_cmd(qcmd),
        .i_target({r_tr, r_tg, r_tb}), .i_steps(r_steps), .i_first(r_first),
        .i_last(r_last), .i_hud(r_hud), .o_valid, .i_stall, .o_argb,
        .o_red(o_red_out), .o_green(o_green_out), .o_blue(o_blue_out), .o_busy(busy)
    );

    `PDF_ASSERT_NOW(a_read_no_argb, o_valid && (o_red_out != 6'd0), o_argb == 32'd0)
    `PDF_ASSERT_NOW(a_pix_no_rgb, o_valid && (o_argb != 32'd0),
        (o_red_out == 6'd0) && (o_green_out == 6'd0) && (o_blue_out == 6'd0))
    `PDF_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_argb))
    `PDF_ASSERT_NOW(a_cfg_idle, i_cfg_we, !busy && !qv)
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives entry writes, reads, pixel lookups and fade steps into the palette
// DAC, predicts every read and lookup word from a private copy of both
// palettes and the registers, and checks each output word in order. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    // one expected output word
    typedef struct {
        logic [31:0] argb;
        logic [5:0]  red;
        logic [5:0]  green;
        logic [5:0]  blue;
    } t_colour;

    // palette predictor and ordered store of expected words
    class palette_scoreboard;
        logic [17:0] base_pal [256];
        logic [17:0] shown_pal [256];
        logic [5:0]  tgt_r, tgt_g, tgt_b;
        logic [7:0]  steps, first, last;
        logic        hud, fen;
        t_colour     pending_colours [$];
        int          errors;

        function new();
            foreach (base_pal[j]) begin
                base_pal[j]  = '0;
                shown_pal[j] = '0;
            end
            tgt_r = 0; tgt_g = 0; tgt_b = 0;
            steps = 8'd30; first = 8'd0; last = 8'd255;
            hud = 1'b0; fen = 1'b1;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                pdf_pkg::CFG_TRED:  tgt_r = v[5:0];
                pdf_pkg::CFG_TGRN:  tgt_g = v[5:0];
                pdf_pkg::CFG_TBLU:  tgt_b = v[5:0];
                pdf_pkg::CFG_STEPS: steps = v;
                pdf_pkg::CFG_FIRST: first = v;
                pdf_pkg::CFG_LAST:  last  = v;
                pdf_pkg::CFG_HUD:   hud   = v[0];
                pdf_pkg::CFG_FEN:   fen   = v[0];
                default: ;
            endcase
        endfunction

        // signed interpolation, truncating toward zero
        function logic [5:0] blend(logic [5:0] o, logic [5:0] t, logic [7:0] i);
            int d, q;
            d = int'(t) - int'(o);
            q = (d * int'(i)) / int'(steps);
            return 6'(int'(o) + q);
        endfunction

        function logic [7:0] widen(logic [5:0] c);
            int w;
            w = (255 * int'(c)) / 63;
            return w[7:0];
        endfunction

        function void note_request(pdf_pkg::t_req req, logic [7:0] idx, logic [5:0] r,
                                   logic [5:0] g, logic [5:0] b, logic mask,
                                   logic [7:0] stp);
            logic [17:0] e, v;
            t_colour     c;
            e = shown_pal[idx];
            case (req)
                pdf_pkg::REQ_WRITE: begin
                    base_pal[idx]  = {r, g, b};
                    shown_pal[idx] = {r, g, b};
                end
                pdf_pkg::REQ_READ: begin
                    c.argb = '0;
                    c.red = e[17:12]; c.green = e[11:6]; c.blue = e[5:0];
                    pending_colours.push_back(c);
                end
                pdf_pkg::REQ_PIXEL: begin
                    c.argb = {8'hFF, widen(e[17:12]), widen(e[11:6]), widen(e[5:0])};
                    if (hud && !mask) c.argb[31:24] = 8'h00;
                    c.red = '0; c.green = '0; c.blue = '0;
                    pending_colours.push_back(c);
                end
                default: begin
                    if (fen && stp < steps) begin
                        foreach (base_pal[j]) begin
                            v = base_pal[j];
                            if (j >= first && j <= last)
                                shown_pal[j] = {blend(v[17:12], tgt_r, stp),
                                                blend(v[11:6], tgt_g, stp),
                                                blend(v[5:0], tgt_b, stp)};
                            else
                                shown_pal[j] = v;
                        end
                    end else begin
                        foreach (base_pal[j]) begin
                            base_pal[j]  = {tgt_r, tgt_g, tgt_b};
                            shown_pal[j] = {tgt_r, tgt_g, tgt_b};
                        end
                    end
                end
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_output(logic [31:0] argb, logic [5:0] r, logic [5:0] g,
                          logic [5:0] b);
            t_colour c;
            if (pending_colours.size() == 0) begin
                report("unexpected word", argb, 0);
            end else begin
                c = pending_colours.pop_front();
                if (argb !== c.argb)  report("argb", argb, c.argb);
                if (r !== c.red)      report("red", r, c.red);
                if (g !== c.green)    report("green", g, c.green);
                if (b !== c.blue)     report("blue", b, c.blue);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_index = '0;
    logic [5:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic        i_mask_bit = 1'b0;
    logic [7:0]  i_step_number = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [31:0] o_argb;
    logic [5:0]  o_red_out, o_green_out, o_blue_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    palette_scoreboard sb = new();
    bit          hold_req = 1'b0;

    palette_dac_with_fade_unit u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output words checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_output(o_argb, o_red_out, o_green_out, o_blue_out);
    end

    // receiver: random stall per word, one long hold on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (n > 0) begin
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall) && !hold_req);
        end
    end

    // offer one word, wait until taken
    task send(pdf_pkg::t_req req, logic [7:0] idx, logic [5:0] r, logic [5:0] g,
              logic [5:0] b, logic mask, logic [7:0] stp, int gap);
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req; i_index <= idx;
        i_red_in <= r; i_green_in <= g; i_blue_in <= b;
        i_mask_bit <= mask; i_step_number <= stp;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req, idx, r, g, b, mask, stp);
    endtask

    // a read behind everything, then idle until all words are back
    task drain();
        send(pdf_pkg::REQ_READ, 8'd0, 0, 0, 0, 0, 0, 0);
        @(negedge i_clk) i_valid <= 1'b0;
        wait (sb.pending_colours.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task write_reg(logic [2:0] idx, logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task rand_gap(output int g);
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    endtask

    // run limit
    initial begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        int   g, ph, k, sel;
        pdf_pkg::t_req rq;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request, HUD, fade, fill, empty range
        send(pdf_pkg::REQ_WRITE, 8'd0, 6'd63, 6'd63, 6'd63, 1, 0, 0);
        send(pdf_pkg::REQ_WRITE, 8'd255, 6'd0, 6'd63, 6'd0, 0, 0, 0);
        send(pdf_pkg::REQ_READ, 8'd0, 0, 0, 0, 0, 0, 0);
        send(pdf_pkg::REQ_READ, 8'd255, 0, 0, 0, 0, 0, 1);
        send(pdf_pkg::REQ_PIXEL, 8'd0, 0, 0, 0, 0, 0, 0);
        send(pdf_pkg::REQ_PIXEL, 8'd128, 0, 0, 0, 1, 0, 0);
        send(pdf_pkg::REQ_FADE, 0, 0, 0, 0, 0, 8'd15, 0);
        send(pdf_pkg::REQ_READ, 8'd0, 0, 0, 0, 0, 0, 0);
        send(pdf_pkg::REQ_PIXEL, 8'd255, 0, 0, 0, 0, 0, 0);
        drain();
        write_reg(pdf_pkg::CFG_HUD, 8'd1);
        write_reg(pdf_pkg::CFG_TRED, 8'd63);
        write_reg(pdf_pkg::CFG_TGRN, 8'd17);
        write_reg(pdf_pkg::CFG_TBLU, 8'd63);
        send(pdf_pkg::REQ_PIXEL, 8'd0, 0, 0, 0, 0, 0, 0);
        send(pdf_pkg::REQ_PIXEL, 8'd0, 0, 0, 0, 1, 0, 0);
        send(pdf_pkg::REQ_FADE, 0, 0, 0, 0, 0, 8'd29, 0);
        send(pdf_pkg::REQ_PIXEL, 8'd255, 0, 0, 0, 0, 0, 0);
        send(pdf_pkg::REQ_FADE, 0, 0, 0, 0, 0, 8'd30, 0);
        send(pdf_pkg::REQ_READ, 8'd7, 0, 0, 0, 0, 0, 0);
        drain();
        write_reg(pdf_pkg::CFG_FIRST, 8'd200);
        write_reg(pdf_pkg::CFG_LAST, 8'd100);
        write_reg(pdf_pkg::CFG_FEN, 8'd0);
        write_reg(pdf_pkg::CFG_STEPS, 8'd0);
        send(pdf_pkg::REQ_WRITE, 8'd100, 6'd21, 6'd42, 6'd0, 0, 0, 0);
        send(pdf_pkg::REQ_FADE, 0, 0, 0, 0, 0, 8'd0, 0);
        send(pdf_pkg::REQ_READ, 8'd100, 0, 0, 0, 0, 0, 0);
        drain();
        write_reg(pdf_pkg::CFG_FEN, 8'd1);
        send(pdf_pkg::REQ_FADE, 0, 0, 0, 0, 0, 8'd0, 0);
        send(pdf_pkg::REQ_READ, 8'd3, 0, 0, 0, 0, 0, 0);
        drain();

        // random phases, each with its own register setting
        for (ph = 0; ph < 6; ph++) begin
            write_reg(pdf_pkg::CFG_TRED, (ph == 1) ? 8'd63 : (ph == 2) ? 8'd0 :
                      8'($urandom_range(0, 63)));
            write_reg(pdf_pkg::CFG_TGRN, (ph == 1) ? 8'd63 : (ph == 2) ? 8'd0 :
                      8'($urandom_range(0, 63)));
            write_reg(pdf_pkg::CFG_TBLU, (ph == 1) ? 8'd63 : (ph == 2) ? 8'd0 :
                      8'($urandom_range(0, 63)));
            write_reg(pdf_pkg::CFG_STEPS, (ph == 1) ? 8'd255 : (ph == 2) ? 8'd1 :
                      8'($urandom_range(1, 255)));
            write_reg(pdf_pkg::CFG_FIRST, (ph == 1) ? 8'd0 : 8'($urandom_range(0, 255)));
            write_reg(pdf_pkg::CFG_LAST, (ph == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
            write_reg(pdf_pkg::CFG_HUD, {7'd0, ph[0]});
            write_reg(pdf_pkg::CFG_FEN, (ph == 4) ? 8'd0 : 8'd1);
            for (k = 0; k < 150; k++) begin
                if (ph == 3 && k == 20) hold_req = 1'b1;
                sel = $urandom_range(0, 99);
                rq = (sel < 30) ? pdf_pkg::REQ_WRITE : (sel < 52) ? pdf_pkg::REQ_READ :
                     (sel < 97) ? pdf_pkg::REQ_PIXEL : pdf_pkg::REQ_FADE;
                rand_gap(g);
                if (ph == 3 && k >= 20 && k < 60) g = 0;
                send(rq, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, sb.steps)),
                     g);
            end
            drain();
        end

        // settle, then verdict
        wait (sb.pending_colours.size() == 0);
        repeat (300) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_colours.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
